/* src/sla_pkg.sv */
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types, constants and the scan code to ASCII table for the scan code
// line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CHAR_W     = 7;

    localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
    localparam logic [7:0] CODE_ENTER     = 8'h1C;
    localparam logic [7:0] CODE_MAX       = 8'd57;

    localparam logic [2:0] EV_ECHO_CHAR = 3'd0;
    localparam logic [2:0] EV_ECHO_BS   = 3'd1;
    localparam logic [2:0] EV_ECHO_NL   = 3'd2;
    localparam logic [2:0] EV_LINE_CHAR = 3'd3;
    localparam logic [2:0] EV_LINE_END  = 3'd4;
    localparam logic [2:0] EV_OVERFLOW  = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [2:0]        event_res;
        logic [CHAR_W-1:0] character;
        logic              last;
    } res_t;

    localparam logic [CHAR_W-1:0] ASCII_MAP [0:57] = '{
        7'h3F, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h3F, 7'h3F,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h3F, 7'h3F, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
        7'h27, 7'h60, 7'h3F, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F,
        7'h3F, 7'h20
    };

    // Codes above the table never reach the lookup; map them to '?' anyway.
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [5:0] code);
        logic [CHAR_W-1:0] ch;
        ch = 7'h3F;
        if (code <= 6'd57) begin
            ch = ASCII_MAP[code];
        end
        return ch;
    endfunction

endpackage

/* src/sla_ram.sv */
// ----------------------------------------------------------------------------
// sla_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module sla_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sla_ctrl.sv */
// ----------------------------------------------------------------------------
// sla_ctrl
// Sequencer: decodes scan codes, keeps the fill count, writes characters
// into the line RAM and drains it on Enter, one result word per cycle unless stalled.
// ----------------------------------------------------------------------------
module sla_ctrl
    import sla_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              code_valid,
    input  logic [7:0]        code,
    output logic              code_ready,
    output res_t              res,
    input  logic              res_ready,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [CHAR_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [CHAR_W-1:0] ram_rdata
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] idx_inc;
    logic [CHAR_W-1:0] mapped;

    assign mapped  = ascii_of(code[5:0]);
    assign idx_inc = idx_reg + FILL_W'(1);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        res        = '0;
        code_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = fill_reg[ADDR_W-1:0];
        ram_wdata  = mapped;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                code_ready = res_ready;
                if (code_valid && res_ready) begin
                    if (code > CODE_MAX) begin
                        // drop releases and extended codes
                    end else if (code == CODE_BACKSPACE) begin
                        res = '{valid: 1'b1, event_res: EV_ECHO_BS, character: '0,
                                last: 1'b1};
                        if (fill_reg != '0) begin
                            fill_next = fill_reg - FILL_W'(1);
                        end
                    end else if (code == CODE_ENTER) begin
                        res = '{valid: 1'b1, event_res: EV_ECHO_NL, character: '0,
                                last: 1'b0};
                        // prefetch entry 0 for the drain
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = ST_DRAIN;
                    end else if (fill_reg == FILL_W'(LINE_DEPTH)) begin
                        res = '{valid: 1'b1, event_res: EV_OVERFLOW, character: '0,
                                last: 1'b1};
                    end else begin
                        res = '{valid: 1'b1, event_res: EV_ECHO_CHAR, character: mapped,
                                last: 1'b1};
                        ram_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (idx_reg == fill_reg) begin
                    res = '{valid: 1'b1, event_res: EV_LINE_END, character: '0,
                            last: 1'b1};
                    if (res_ready) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    res = '{valid: 1'b1, event_res: EV_LINE_CHAR, character: ram_rdata,
                            last: 1'b0};
                    // advance only when taken; RAM output holds otherwise
                    if (res_ready) begin
                        idx_next  = idx_inc;
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[ADDR_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("line RAM written during drain");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (idx_reg <= fill_reg))
        else $error("drain index passed fill count");

    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && idx_reg == fill_reg && res_ready)
            |=> (state_reg == ST_IDLE && fill_reg == '0))
        else $error("drain did not close the line");

endmodule

/* src/scancode_line_assembler_top.sv */
// ----------------------------------------------------------------------------
// scancode_line_assembler_top
// Scan code line assembler: set-1 make codes in, echo and line events out.
// ----------------------------------------------------------------------------
// Input stream: one scan code byte per word on s_axis_tdata[7:0].
// Output stream: m_axis_tuser carries the event kind, m_axis_tdata the ASCII
// character (zero where none applies), m_axis_tlast marks the final word
// caused by one input word. Codes above 57 produce no output word.
// The first result word appears in the cycle after acceptance, from the output
// register. An ordinary key, backspace or overflow gives one output word per
// input word. Enter gives the newline echo, one line character per cycle read
// back from the line RAM while the receiver takes them, then the line end.
// The drain rate is set by the single read port of the line RAM.
// Reset empties the line (fill count zero) and the output register; the RAM
// contents are not cleared and only entries below the fill count are sent out.
// When the receiver stalls, the output register holds its word, the drain
// pauses and s_axis_tready drops until the word is taken.
// ----------------------------------------------------------------------------
module scancode_line_assembler_top
    import sla_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] character, [7] zero
    output logic [2:0] m_axis_tuser,   // [2:0] event_res
    output logic       m_axis_tlast
);

    res_t              res;
    logic              res_ready;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic              out_valid_reg;
    logic [2:0]        out_event_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;

    sla_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .code_valid (s_axis_tvalid),
        .code       (s_axis_tdata),
        .code_ready (s_axis_tready),
        .res        (res),
        .res_ready  (res_ready),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    sla_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register accepts a new word when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            out_event_reg <= res.event_res;
            out_char_reg  <= res.character;
            out_last_reg  <= res.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tuser  = out_event_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
